// File: sv/aeske_pkg.sv
// ----------------------------------------------------------------------------
// aeske_pkg: shared constants and tables for the AES-256 key expansion unit
// S-box, round constants, schedule sizes and special word positions
// ----------------------------------------------------------------------------
package aeske_pkg;

    localparam int KEY_WORDS   = 8;
    localparam int SCHED_WORDS = 60;
    localparam int IDX_W       = 6;
    localparam int LOAD_W      = 3;

    // positions within each group of eight schedule words
    localparam logic [2:0] POS_ROT_SUB = 3'd0;
    localparam logic [2:0] POS_SUB     = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCHED_WORDS - 1);

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // round constant, top byte of the word
    function automatic logic [7:0] rcon_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            4'd11:   r = 8'h6c;
            4'd12:   r = 8'hd8;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // four parallel s-box lookups
    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

endpackage

// File: sv/aes256_key_expansion_unit.sv
// ----------------------------------------------------------------------------
// aes256_key_expansion_unit: AES-256 key schedule generator
// latency: first schedule word is valid the cycle after the eighth key word
// schedule: 8 key loads, then 60 words at one per cycle while m_ready holds,
//   each from the single sub-word unit; the next key waits for the last word
// reset: synchronous active-low aresetn clears the key window and load count
// ----------------------------------------------------------------------------
module aes256_key_expansion_unit
    import aeske_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_key_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_round_key_word,
    output logic [5:0]  m_word_index,
    output logic        m_last
);

    typedef enum logic {ST_LOAD, ST_EMIT} state_t;

    state_t              state_reg;
    logic [LOAD_W-1:0]   load_count_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [31:0]         win_reg [KEY_WORDS];

    logic        s_fire;
    logic        m_fire;
    logic [2:0]  pos;
    logic [3:0]  rcon_idx;
    logic [31:0] last_word;
    logic [31:0] sub_in;
    logic [31:0] sub_out;
    logic [31:0] temp_word;
    logic [31:0] new_word;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // window head is word idx, tail is word idx+7; next word is idx+8
    assign pos       = idx_reg[2:0];
    assign rcon_idx  = 4'({1'b0, idx_reg[5:3]}) + 4'd1;
    assign last_word = win_reg[KEY_WORDS-1];
    assign sub_in    = (pos == POS_ROT_SUB) ? {last_word[23:0], last_word[31:24]} : last_word;
    assign sub_out   = sub_word(sub_in);

    always_comb begin
        case (pos)
            POS_ROT_SUB: temp_word = sub_out ^ {rcon_byte(rcon_idx), 24'h0};
            POS_SUB:     temp_word = sub_out;
            default:     temp_word = last_word;
        endcase
    end

    assign new_word = win_reg[0] ^ temp_word;

    // sequencer: load eight words, then stream the schedule
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            idx_reg        <= '0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        load_count_reg <= load_count_reg + 1'b1;
                        if (load_count_reg == LOAD_W'(KEY_WORDS - 1)) begin
                            state_reg <= ST_EMIT;
                            idx_reg   <= '0;
                        end
                    end
                end
                ST_EMIT: begin
                    if (m_fire) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // key window shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s_fire || m_fire) begin
            for (int i = 0; i < KEY_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[KEY_WORDS-1] <= s_fire ? s_key_word : new_word;
        end
    end

    // outputs
    assign s_ready          = (state_reg == ST_LOAD);
    assign m_valid          = (state_reg == ST_EMIT);
    assign m_round_key_word = win_reg[0];
    assign m_word_index     = idx_reg;
    assign m_last           = (idx_reg == LAST_IDX);

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output both open");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg <= LAST_IDX))
        else $error("word index out of range");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && !m_last) |=> (m_valid && idx_reg == $past(idx_reg) + 1'b1))
        else $error("word index did not advance");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last) |=> (s_ready && load_count_reg == '0))
        else $error("run did not return to loading");

    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && load_count_reg == LOAD_W'(KEY_WORDS - 1)) |=> (m_valid && idx_reg == '0))
        else $error("schedule did not start at word zero");

endmodule

// File: tb/key_schedule_checker.sv
// ----------------------------------------------------------------------------
// key_schedule_checker: scoreboard for the AES-256 key expansion unit
// Watches both channels of the block, rebuilds the 60-word key schedule from
// every eight accepted key words, and compares each schedule word that the
// block hands out with the oldest word still expected. A failure count and
// the number of words still outstanding go back to the testbench top.
// ----------------------------------------------------------------------------
module key_schedule_checker
    import aeske_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_key_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_round_key_word,
    input  logic [5:0]  m_word_index,
    input  logic        m_last,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0]      word;
        logic [IDX_W-1:0] index;
        logic             last;
    } sched_entry_t;

    localparam int REPORT_MAX = 10;

    // round constants, top byte, indexed by schedule word position / 8
    localparam logic [7:0] ROUND_CONST [13] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
        8'h40, 8'h80, 8'h1b, 8'h36, 8'h6c, 8'hd8
    };

    logic [31:0]       key_window [KEY_WORDS];
    logic [LOAD_W-1:0] load_count;
    logic [31:0]       sched_words [SCHED_WORDS];
    sched_entry_t      expected_words [$];
    sched_entry_t      head;
    int                errs;
    int                reported;

    // byte-wise s-box substitution
    function automatic logic [31:0] subst_bytes(input logic [31:0] x);
        logic [31:0] r;
        for (int b = 0; b < 4; b++) begin
            r[8*b +: 8] = SBOX[x[8*b +: 8]];
        end
        return r;
    endfunction

    // one schedule word from the word eight back and the previous word
    function automatic logic [31:0] derive_word(input logic [31:0] back8,
                                                input logic [31:0] prev,
                                                input int          pos);
        logic [31:0] t;
        logic [2:0]  phase;
        phase = pos[2:0];
        t     = prev;
        if (phase == POS_ROT_SUB) begin
            t = subst_bytes({prev[23:0], prev[31:24]}) ^ {ROUND_CONST[pos / 8], 24'h0};
        end else if (phase == POS_SUB) begin
            t = subst_bytes(prev);
        end
        return back8 ^ t;
    endfunction

    // results first, then the request of the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) key_window[i] = '0;
            load_count = '0;
            expected_words.delete();
            errs        = 0;
            reported    = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end else begin
            // compare a delivered schedule word with the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    errs++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("unexpected schedule word: word %h index %0d last %b",
                                 m_round_key_word, m_word_index, m_last);
                    end
                end else begin
                    head = expected_words.pop_front();
                    if (head.word !== m_round_key_word || head.index !== m_word_index ||
                        head.last !== m_last) begin
                        errs++;
                        if (reported < REPORT_MAX) begin
                            reported++;
                            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     head.word, head.index, head.last,
                                     m_round_key_word, m_word_index, m_last);
                        end
                    end
                end
            end

            // store the key word, expand on the eighth
            if (s_valid && s_ready) begin
                key_window[load_count] = s_key_word;
                if (load_count == LOAD_W'(KEY_WORDS - 1)) begin
                    for (int i = 0; i < SCHED_WORDS; i++) begin
                        if (i < KEY_WORDS) begin
                            sched_words[i] = key_window[i];
                        end else begin
                            sched_words[i] = derive_word(sched_words[i - KEY_WORDS],
                                                         sched_words[i - 1], i);
                        end
                        expected_words.push_back('{word:  sched_words[i],
                                                   index: IDX_W'(i),
                                                   last:  (i == SCHED_WORDS - 1)});
                    end
                end
                load_count = load_count + 1'b1;
            end

            fail_count  <= errs;
            outstanding <= expected_words.size();
        end
    end

endmodule

// File: tb/aes256_key_expansion_unit_tb.sv
// ----------------------------------------------------------------------------
// aes256_key_expansion_unit_tb: testbench top for the AES-256 key expansion
// Feeds directed keys (all zeros, all ones, the standard test key) and then
// random keys in bursts with gaps, stalls the schedule output on changing
// patterns and once for a long stretch, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module aes256_key_expansion_unit_tb
    import aeske_pkg::*;
();

    localparam int RANDOM_KEYS = 12;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;
    typedef enum int {KEY_FULL, KEY_FEW_BITS, KEY_BYTE_MIX, KEY_EDGE} key_style_t;

    logic        aclk;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [31:0] s_key_word = '0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic [31:0] m_round_key_word;
    logic [5:0]  m_word_index;
    logic        m_last;

    int   fail_count;
    int   outstanding;
    int   burst_left = 0;
    logic hold_req   = 1'b0;

    aes256_key_expansion_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_word       (s_key_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_round_key_word (m_round_key_word),
        .m_word_index     (m_word_index),
        .m_last           (m_last)
    );

    key_schedule_checker chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_word       (s_key_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_round_key_word (m_round_key_word),
        .m_word_index     (m_word_index),
        .m_last           (m_last),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // reset, once
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("aes256_key_expansion_unit_tb: FAIL");
        $finish;
    end

    // offer one key word, with a random gap at the start of each burst
    task automatic offer_word(input logic [31:0] w);
        int   gap;
        logic got;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_key_word <= w;
        do begin
            @(negedge aclk);
            got = s_ready;
            @(posedge aclk);
        end while (!got);
    endtask

    // hold the input off until every expected schedule word has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_key_word(input key_style_t style);
        logic [31:0] w;
        w = '0;
        case (style)
            KEY_FULL:     w = $urandom;
            KEY_FEW_BITS: begin
                w[$urandom_range(0, 31)] = 1'b1;
                w[$urandom_range(0, 31)] = 1'b1;
            end
            KEY_BYTE_MIX: begin
                for (int b = 0; b < 4; b++) begin
                    case ($urandom_range(0, 2))
                        0:       w[8*b +: 8] = 8'h00;
                        1:       w[8*b +: 8] = 8'hff;
                        default: w[8*b +: 8] = 8'($urandom);
                    endcase
                end
            end
            default:      w = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        endcase
        return w;
    endfunction

    // request side: directed keys, a drain, then random keys
    initial begin
        key_style_t style;
        do @(negedge aclk); while (!aresetn);
        @(posedge aclk);

        // all-zero key, all-one key, standard test key 00 01 .. 1f
        for (int i = 0; i < KEY_WORDS; i++) offer_word(32'h0000_0000);
        for (int i = 0; i < KEY_WORDS; i++) offer_word(32'hffff_ffff);
        for (int i = 0; i < KEY_WORDS; i++) begin
            offer_word({8'(4*i), 8'(4*i + 1), 8'(4*i + 2), 8'(4*i + 3)});
        end

        wait_drained();
        hold_req <= 1'b1;

        for (int k = 0; k < RANDOM_KEYS; k++) begin
            style = key_style_t'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) style = KEY_FULL;
            for (int i = 0; i < KEY_WORDS; i++) offer_word(pick_key_word(style));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("aes256_key_expansion_unit_tb: PASS");
        end else begin
            $display("aes256_key_expansion_unit_tb: FAIL");
        end
        $finish;
    end

    // result side: changing stall patterns, one long hold-off
    initial begin
        rx_mode_t mode;
        int       seg_left;
        int       hold_left;
        logic     hold_done;
        mode      = RX_OPEN;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 150);
                    mode     = rx_mode_t'($urandom_range(0, 3));
                end
                seg_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (seg_left % 5 != 0);
                endcase
            end
        end
    end

endmodule
